[hw/rtl/allfl_pkg.sv]
// Package for the array linked list with free list.
// Shared defaults, operation codes and sequencer states; no dependencies.
package allfl_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int KEY_WIDTH_DEF     = 16;
  localparam int PAYLOAD_WIDTH_DEF = 32;
  localparam int FUNC_W            = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_SORTED = 2'd1,
    FUNC_REMOVE = 2'd2
  } allfl_func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_TAKE,
    ST_LINK,
    ST_REMOVE,
    ST_DONE
  } allfl_state_e;

endpackage

[hw/rtl/allfl_if.sv]
// Valid/ready channel interfaces for request and response words.
// Depends on allfl_pkg for the operation code width.
interface allfl_req_if #(
  parameter int KEY_WIDTH     = allfl_pkg::KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = allfl_pkg::PAYLOAD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [allfl_pkg::FUNC_W-1:0]  func;
  logic [KEY_WIDTH-1:0]          record_key;
  logic [PAYLOAD_WIDTH-1:0]      record_payload;

  modport source (output valid, output func, output record_key, output record_payload,
                  input ready);
  modport sink   (input valid, input func, input record_key, input record_payload,
                  output ready);
endinterface

interface allfl_rsp_if #(
  parameter int KEY_WIDTH     = allfl_pkg::KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = allfl_pkg::PAYLOAD_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic                     success;
  logic [KEY_WIDTH-1:0]     removed_key;
  logic [PAYLOAD_WIDTH-1:0] removed_payload;
  logic                     list_empty;
  logic                     pool_full;

  modport source (output valid, output success, output removed_key,
                  output removed_payload, output list_empty, output pool_full,
                  input ready);
  modport sink   (input valid, input success, input removed_key,
                  input removed_payload, input list_empty, input pool_full,
                  output ready);
endinterface

[hw/rtl/allfl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module allfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/array_linked_list_with_free_list_top.sv]
// Top level: linked list of records in a fixed node pool, with a free list.
// Depends on allfl_pkg, allfl_if (request/response channels) and allfl_ram.
//
//   channel | dir | words carried
//   --------+-----+------------------------------------------------------------
//   req_i   | in  | func, record_key, record_payload
//   rsp_o   | out | success, removed_key, removed_payload, list_empty, pool_full
//
// One word at a time: append runs take, link, done; remove runs remove, done;
// sorted insert walks, then runs take, link, done. The walk reads one node per cycle
// from the key/payload and link RAMs, and one shared key compare decides each step.
// Reset leaves no clearing pass: untouched nodes are tracked by a fill count.
// A pending response word holds in its output register; the next request is
// taken meanwhile and waits at its final step until that word is taken.
module array_linked_list_with_free_list_top #(
  parameter int DEPTH         = allfl_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH     = allfl_pkg::KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = allfl_pkg::PAYLOAD_WIDTH_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  allfl_req_if.sink   req_i,
  allfl_rsp_if.source rsp_o
);
  import allfl_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;
  localparam int DW = KEY_WIDTH + PAYLOAD_WIDTH;
  localparam logic [PW-1:0] NONE = {PW{1'b1}};

  function automatic logic is_node(input logic [PW-1:0] p);
    return p < PW'(DEPTH);
  endfunction

  allfl_state_e state_q, state_d;
  logic [PW-1:0] head_q, head_d, tail_q, tail_d, free_q, free_d, fresh_q, fresh_d;
  logic [PW-1:0] prev_q, prev_d, cur_q, cur_d, node_q, node_d;
  logic [PW-1:0] free_nxt;
  logic [KEY_WIDTH-1:0]     key_q, key_d, rkey_q, rkey_d;
  logic [PAYLOAD_WIDTH-1:0] pay_q, pay_d, rpay_q, rpay_d;
  logic ok_q, ok_d;

  logic                     rsp_vq, rsp_vd;
  logic                     rsp_ok_q, rsp_ok_d, rsp_empty_q, rsp_empty_d;
  logic                     rsp_full_q, rsp_full_d;
  logic [KEY_WIDTH-1:0]     rsp_key_q, rsp_key_d;
  logic [PAYLOAD_WIDTH-1:0] rsp_pay_q, rsp_pay_d;

  logic          d_we, l_we;
  logic [AW-1:0] d_waddr, d_raddr, l_waddr, l_raddr;
  logic [DW-1:0] d_wdata, d_rdata;
  logic [PW-1:0] l_wdata, l_rdata;
  logic [KEY_WIDTH-1:0] node_key;
  logic          key_gt;

  allfl_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  allfl_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  assign node_key = d_rdata[DW-1:PAYLOAD_WIDTH];
  assign key_gt   = node_key > key_q;
  assign free_nxt = node_q + PW'(1);
  assign d_wdata  = {key_q, pay_q};

  assign req_i.ready           = (state_q == ST_IDLE);
  assign rsp_o.valid           = rsp_vq;
  assign rsp_o.success         = rsp_ok_q;
  assign rsp_o.removed_key     = rsp_key_q;
  assign rsp_o.removed_payload = rsp_pay_q;
  assign rsp_o.list_empty      = rsp_empty_q;
  assign rsp_o.pool_full       = rsp_full_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    free_d      = free_q;
    fresh_d     = fresh_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    node_d      = node_q;
    key_d       = key_q;
    pay_d       = pay_q;
    ok_d        = ok_q;
    rkey_d      = rkey_q;
    rpay_d      = rpay_q;
    rsp_vd      = rsp_vq && !rsp_o.ready;
    rsp_ok_d    = rsp_ok_q;
    rsp_key_d   = rsp_key_q;
    rsp_pay_d   = rsp_pay_q;
    rsp_empty_d = rsp_empty_q;
    rsp_full_d  = rsp_full_q;
    d_we        = 1'b0;
    d_waddr     = node_q[AW-1:0];
    d_raddr     = head_q[AW-1:0];
    l_we        = 1'b0;
    l_waddr     = node_q[AW-1:0];
    l_wdata     = cur_q;
    l_raddr     = head_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          key_d   = req_i.record_key;
          pay_d   = req_i.record_payload;
          ok_d    = 1'b0;
          rkey_d  = '0;
          rpay_d  = '0;
          node_d  = free_q;
          state_d = ST_DONE;
          unique case (allfl_func_e'(req_i.func))
            FUNC_APPEND: begin
              if (is_node(free_q)) begin
                ok_d    = 1'b1;
                prev_d  = tail_q;
                cur_d   = NONE;
                l_raddr = free_q[AW-1:0];
                state_d = ST_TAKE;
              end
            end
            FUNC_SORTED: begin
              if (is_node(free_q)) begin
                ok_d   = 1'b1;
                prev_d = NONE;
                cur_d  = head_q;
                if (is_node(head_q)) begin
                  state_d = ST_WALK;
                end else begin
                  l_raddr = free_q[AW-1:0];
                  state_d = ST_TAKE;
                end
              end
            end
            FUNC_REMOVE: begin
              if (is_node(head_q)) begin
                ok_d    = 1'b1;
                state_d = ST_REMOVE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        // RAM words of cur_q are on the read ports this cycle
        if (key_gt) begin
          l_raddr = node_q[AW-1:0];
          state_d = ST_TAKE;
        end else begin
          prev_d = cur_q;
          if (is_node(l_rdata)) begin
            cur_d   = l_rdata;
            d_raddr = l_rdata[AW-1:0];
            l_raddr = l_rdata[AW-1:0];
          end else begin
            cur_d   = NONE;
            l_raddr = node_q[AW-1:0];
            state_d = ST_TAKE;
          end
        end
      end
      ST_TAKE: begin
        d_we    = 1'b1;
        l_we    = 1'b1;
        l_wdata = cur_q;
        if (node_q < fresh_q) begin
          free_d = is_node(l_rdata) ? l_rdata : NONE;
        end else begin
          // untouched node: its implicit link is the next index
          free_d  = is_node(free_nxt) ? free_nxt : NONE;
          fresh_d = fresh_q + PW'(1);
        end
        state_d = ST_LINK;
      end
      ST_LINK: begin
        if (is_node(prev_q)) begin
          l_we    = 1'b1;
          l_waddr = prev_q[AW-1:0];
          l_wdata = node_q;
        end else begin
          head_d = node_q;
        end
        if (!is_node(cur_q)) begin
          tail_d = node_q;
        end
        state_d = ST_DONE;
      end
      ST_REMOVE: begin
        rkey_d  = node_key;
        rpay_d  = d_rdata[PAYLOAD_WIDTH-1:0];
        if (is_node(l_rdata)) begin
          head_d = l_rdata;
        end else begin
          head_d = NONE;
          tail_d = NONE;
        end
        l_we    = 1'b1;
        l_waddr = head_q[AW-1:0];
        l_wdata = free_q;
        free_d  = head_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_vq || rsp_o.ready) begin
          rsp_vd      = 1'b1;
          rsp_ok_d    = ok_q;
          rsp_key_d   = rkey_q;
          rsp_pay_d   = rpay_q;
          rsp_empty_d = !is_node(head_q);
          rsp_full_d  = !is_node(free_q);
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= NONE;
      tail_q  <= NONE;
      free_q  <= '0;
      fresh_q <= '0;
      rsp_vq  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      free_q  <= free_d;
      fresh_q <= fresh_d;
      rsp_vq  <= rsp_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q      <= prev_d;
    cur_q       <= cur_d;
    node_q      <= node_d;
    key_q       <= key_d;
    pay_q       <= pay_d;
    ok_q        <= ok_d;
    rkey_q      <= rkey_d;
    rpay_q      <= rpay_d;
    rsp_ok_q    <= rsp_ok_d;
    rsp_key_q   <= rsp_key_d;
    rsp_pay_q   <= rsp_pay_d;
    rsp_empty_q <= rsp_empty_d;
    rsp_full_q  <= rsp_full_d;
  end

  a_head_tail_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (is_node(head_q) == is_node(tail_q)))
    else $error("head and tail disagree on list emptiness");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= PW'(DEPTH))
    else $error("fill count beyond pool depth");

  a_not_full_and_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (is_node(free_q) || is_node(head_q)))
    else $error("pool full while list empty");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_vq) |-> ($past(state_q) == ST_DONE))
    else $error("response word raised outside final step");

endmodule

[bench/array_linked_list_with_free_list_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the array linked list: mirrors the node pool and free list,
// predicts one response word per request word and compares. Needs allfl_pkg, allfl_if.
module array_linked_list_with_free_list_checker #(
  parameter int DEPTH         = allfl_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH     = allfl_pkg::KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = allfl_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  allfl_req_if   req_i,
  allfl_rsp_if   rsp_i,
  output int     fail_count_o,
  output int     words_pending_o
);
  import allfl_pkg::*;

  localparam int NO_NODE = -1;

  typedef struct packed {
    logic                     success;
    logic [KEY_WIDTH-1:0]     removed_key;
    logic [PAYLOAD_WIDTH-1:0] removed_payload;
    logic                     list_empty;
    logic                     pool_full;
  } outcome_t;

  logic [KEY_WIDTH-1:0]     pool_key     [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] pool_payload [DEPTH];
  int                       pool_next    [DEPTH];
  int                       list_head;
  int                       list_tail;
  int                       free_head;

  outcome_t outcome_q [$];
  int       fail_total;

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      pool_key[i]     = '0;
      pool_payload[i] = '0;
      pool_next[i]    = (i + 1 < DEPTH) ? i + 1 : NO_NODE;
    end
    list_head  = NO_NODE;
    list_tail  = NO_NODE;
    free_head  = 0;
    fail_total = 0;
  end

  // Updates the mirrored pool for one request word and returns its response.
  function automatic outcome_t apply_word(logic [FUNC_W-1:0] func,
                                          logic [KEY_WIDTH-1:0] key,
                                          logic [PAYLOAD_WIDTH-1:0] payload);
    outcome_t res;
    int       prev;
    int       cur;
    int       n;
    res = '0;
    case (func)
      FUNC_APPEND, FUNC_SORTED: begin
        if (free_head != NO_NODE) begin
          // append is a splice between the tail and nothing
          prev = list_tail;
          cur  = NO_NODE;
          if (func == FUNC_SORTED) begin
            prev = NO_NODE;
            cur  = list_head;
            for (int steps = 0; steps < DEPTH && cur != NO_NODE; steps++) begin
              if (pool_key[cur] > key) break;
              prev = cur;
              cur  = pool_next[cur];
            end
          end
          n               = free_head;
          free_head       = pool_next[n];
          pool_key[n]     = key;
          pool_payload[n] = payload;
          pool_next[n]    = cur;
          if (prev != NO_NODE) pool_next[prev] = n;
          else list_head = n;
          if (cur == NO_NODE) list_tail = n;
          res.success = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (list_head != NO_NODE) begin
          n                   = list_head;
          res.removed_key     = pool_key[n];
          res.removed_payload = pool_payload[n];
          list_head           = pool_next[n];
          if (list_head == NO_NODE) list_tail = NO_NODE;
          pool_next[n]        = free_head;
          free_head           = n;
          res.success         = 1'b1;
        end
      end
      default: ;  // unused code: no change
    endcase
    res.list_empty = (list_head == NO_NODE);
    res.pool_full  = (free_head == NO_NODE);
    return res;
  endfunction

  task automatic note_failure(string why, outcome_t want, outcome_t got);
    fail_total++;
    if (fail_total <= 10) begin
      $display("%0t rsp %s: exp ok=%0b key=%h pay=%h empty=%0b full=%0b", $time, why,
               want.success, want.removed_key, want.removed_payload, want.list_empty,
               want.pool_full);
      $display("%0t          got ok=%0b key=%h pay=%h empty=%0b full=%0b", $time,
               got.success, got.removed_key, got.removed_payload, got.list_empty,
               got.pool_full);
    end
  endtask

  always @(posedge clk_i) begin : watch
    outcome_t got;
    outcome_t want;
    if (rst_ni) begin
      // response first: it always belongs to an older request word
      if (rsp_i.valid && rsp_i.ready) begin
        got.success         = rsp_i.success;
        got.removed_key     = rsp_i.removed_key;
        got.removed_payload = rsp_i.removed_payload;
        got.list_empty      = rsp_i.list_empty;
        got.pool_full       = rsp_i.pool_full;
        if (outcome_q.size() == 0) begin
          note_failure("unexpected word", '0, got);
        end else begin
          want = outcome_q.pop_front();
          if (got.success !== want.success || got.removed_key !== want.removed_key ||
              got.removed_payload !== want.removed_payload ||
              got.list_empty !== want.list_empty || got.pool_full !== want.pool_full) begin
            note_failure("mismatch", want, got);
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        outcome_q.push_back(apply_word(req_i.func, req_i.record_key, req_i.record_payload));
      end
    end
    fail_count_o    <= fail_total;
    words_pending_o <= outcome_q.size();
  end

endmodule

[bench/array_linked_list_with_free_list_top_tb.sv]
`timescale 1ns / 1ps
// Top of the array linked list bench: clock, reset, request stimulus and
// response stalls; the checker module does the scoreboarding. Needs allfl_pkg, allfl_if.
module array_linked_list_with_free_list_top_tb;
  import allfl_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int KW    = KEY_WIDTH_DEF;
  localparam int PW    = PAYLOAD_WIDTH_DEF;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int RANDOM_WORDS = 830;
  localparam int CALM_WORDS   = 120;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   words_pending;
  bit   idle_on;

  allfl_req_if #(.KEY_WIDTH(KW), .PAYLOAD_WIDTH(PW)) req_ch ();
  allfl_rsp_if #(.KEY_WIDTH(KW), .PAYLOAD_WIDTH(PW)) rsp_ch ();

  array_linked_list_with_free_list_top #(
    .DEPTH(DEPTH), .KEY_WIDTH(KW), .PAYLOAD_WIDTH(PW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  array_linked_list_with_free_list_checker #(
    .DEPTH(DEPTH), .KEY_WIDTH(KW), .PAYLOAD_WIDTH(PW)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_ch),
    .rsp_i          (rsp_ch),
    .fail_count_o   (fail_count),
    .words_pending_o(words_pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Small keys often, so equal keys meet in the sorted walk.
  function automatic logic [KW-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return KW'($urandom_range(0, 7));
      default: return KW'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [FUNC_W-1:0] func, input logic [KW-1:0] key,
                           input logic [PW-1:0] payload);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid          <= 1'b1;
    req_ch.func           <= func;
    req_ch.record_key     <= key;
    req_ch.record_payload <= payload;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
  endtask

  // Response side stalls in bursts while idle_on is set.
  initial begin : rsp_side
    int burst;
    burst = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (burst > 0) begin
        burst--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 2);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stim
    int               counted;
    int               phase;
    int               phase_len;
    int               fill_pct;
    int               r;
    logic [KW-1:0]    mid_key;
    rst_ni                <= 1'b0;
    req_ch.valid          <= 1'b0;
    req_ch.func           <= FUNC_APPEND;
    req_ch.record_key     <= '0;
    req_ch.record_payload <= '0;
    idle_on               <= 1'b0;
    mid_key = {1'b1, {(KW - 1){1'b0}}};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty remove, unused code, ordering corner cases, full pool
    send_word(FUNC_REMOVE, '1, '1);
    send_word(FUNC_UNUSED, '1, '1);
    send_word(FUNC_SORTED, mid_key, PW'($urandom));
    send_word(FUNC_APPEND, '1, '1);
    send_word(FUNC_SORTED, '0, '0);                 // new head
    send_word(FUNC_SORTED, mid_key, PW'($urandom)); // lands after equal key
    send_word(FUNC_SORTED, '1, PW'($urandom));      // equal to tail key
    for (int i = 0; i < DEPTH - 5; i++) begin
      send_word((i % 2) ? FUNC_SORTED : FUNC_APPEND, pick_key(), PW'($urandom));
    end
    send_word(FUNC_APPEND, pick_key(), PW'($urandom));
    send_word(FUNC_SORTED, pick_key(), PW'($urandom));
    send_word(FUNC_REMOVE, '0, '0);
    send_word(FUNC_REMOVE, '0, '0);
    send_word(FUNC_SORTED, '0, '1);

    // random: phases lean toward filling, mixing or draining
    counted = 0;
    phase   = 0;
    while (counted < RANDOM_WORDS) begin
      idle_on <= (counted < RANDOM_WORDS - CALM_WORDS) && ($urandom_range(0, 4) != 0);
      case (phase % 3)
        0:       fill_pct = 75;
        1:       fill_pct = 50;
        default: fill_pct = 25;
      endcase
      phase_len = $urandom_range(20, 60);
      for (int i = 0; i < phase_len && counted < RANDOM_WORDS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          send_word(FUNC_UNUSED, pick_key(), PW'($urandom));
        end else begin
          counted++;
          if (r < fill_pct) begin
            send_word($urandom_range(0, 1) ? FUNC_SORTED : FUNC_APPEND, pick_key(),
                      PW'($urandom));
          end else begin
            send_word(FUNC_REMOVE, pick_key(), PW'($urandom));
          end
        end
      end
      // after the mixing phase, sender holds off until every response is back
      if (phase == 1) drain_responses();
      phase++;
    end

    drain_responses();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[array_linked_list_with_free_list_top] OK");
    end else begin
      $display("[array_linked_list_with_free_list_top] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("[array_linked_list_with_free_list_top] ERROR");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/allfl_pkg.sv
hw/rtl/allfl_if.sv
hw/rtl/allfl_ram.sv
hw/rtl/array_linked_list_with_free_list_top.sv
bench/array_linked_list_with_free_list_checker.sv
bench/array_linked_list_with_free_list_top_tb.sv
